// ===== rtl/core/ring_tap_event_hit_test_unit_assert.svh =====
// assertion macros for the ring tap event hit test unit
`ifndef RING_TAP_EVENT_HIT_TEST_UNIT_ASSERT_SVH
`define RING_TAP_EVENT_HIT_TEST_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define RTEHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rteht assertion failed");

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define RTEHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rteht assertion failed");

`else

`define RTEHT_ASSERT_IMP(label, ante, cons)
`define RTEHT_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/rteht_pkg.sv =====
// shared types and constants of the ring tap event hit test unit
`default_nettype none

package rteht_pkg;

  localparam int MAX_EVENTS_DEF = 32;

  localparam int MIN_W = 11;
  localparam int PIX_W = 8;
  localparam int THK_W = 6;
  localparam int IDX_OUT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [10:0] DAY_MINUTES = 11'd1440;
  localparam logic [10:0] MINUTES_PER_POINT = 11'd15;
  localparam logic [10:0] RING_SHIFT_MINUTES = 11'd540;
  localparam logic [4:0]  SIDE_POINTS = 5'd24;
  localparam logic [4:0]  SIDE_LAST = 5'd23;

  // floor(m / 3) == (m * 683) >> 11 for m below 2048
  localparam logic [14:0] RECIP3 = 15'd683;

  localparam logic [7:0] LAYER_X_RST = 8'd0;
  localparam logic [7:0] LAYER_Y_RST = 8'd0;
  localparam logic [7:0] LAYER_W_RST = 8'd144;
  localparam logic [7:0] LAYER_H_RST = 8'd168;
  localparam logic [5:0] RING_THK_RST = 6'd10;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_LAYER_X   = 3'd0,
    CFG_LAYER_Y   = 3'd1,
    CFG_LAYER_W   = 3'd2,
    CFG_LAYER_H   = 3'd3,
    CFG_RING_THK  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic query;
    logic geom;
    logic divs;
    logic pt_step;
    logic minute;
    logic ev_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pt_last;
    logic ev_empty;
    logic ev_last;
    logic ev_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/rteht_in_if.sv =====
// input word channel of the ring tap event hit test unit
`default_nettype none

interface rteht_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [rteht_pkg::MIN_W-1:0]   start_minute;
  logic [rteht_pkg::MIN_W-1:0]   end_minute;
  logic [rteht_pkg::PIX_W-1:0]   tap_x;
  logic [rteht_pkg::PIX_W-1:0]   tap_y;

  modport source (
    output valid, operation, start_minute, end_minute, tap_x, tap_y,
    input  ready
  );
  modport sink (
    input  valid, operation, start_minute, end_minute, tap_x, tap_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rteht_out_if.sv =====
// result word channel of the ring tap event hit test unit
`default_nettype none

interface rteht_out_if;
  logic                              valid;
  logic                              ready;
  logic [rteht_pkg::IDX_OUT_W-1:0]   event_index;
  logic                              found;
  logic [rteht_pkg::MIN_W-1:0]       minute_of_day;

  modport source (
    output valid, event_index, found, minute_of_day,
    input  ready
  );
  modport sink (
    input  valid, event_index, found, minute_of_day,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/rteht_ctrl.sv =====
// sequencing state machine of the ring tap event hit test unit
`default_nettype none

module rteht_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_operation,
  output logic                    in_ready,
  input  wire rteht_pkg::status_t status,
  output rteht_pkg::cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_GEOM     = 9'b000000010,
    S_DIVS     = 9'b000000100,
    S_PTS      = 9'b000001000,
    S_PT_DRAIN = 9'b000010000,
    S_MINUTE   = 9'b000100000,
    S_EVS      = 9'b001000000,
    S_EV_DRAIN = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_operation)
            rteht_pkg::OP_CLEAR:  cmd.clear = 1'b1;
            rteht_pkg::OP_APPEND: cmd.append = 1'b1;
            rteht_pkg::OP_QUERY: begin
              cmd.query = 1'b1;
              state_nxt = S_GEOM;
            end
            default: ;
          endcase
        end
      end
      S_GEOM: begin
        cmd.geom  = 1'b1;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.divs  = 1'b1;
        state_nxt = S_PTS;
      end
      S_PTS: begin
        cmd.pt_step = 1'b1;
        if (status.pt_last) begin
          state_nxt = S_PT_DRAIN;
        end
      end
      S_PT_DRAIN: state_nxt = S_MINUTE;
      S_MINUTE: begin
        cmd.minute = 1'b1;
        state_nxt  = status.ev_empty ? S_RESULT : S_EVS;
      end
      S_EVS: begin
        cmd.ev_step = 1'b1;
        if (status.ev_last) begin
          state_nxt = S_EV_DRAIN;
        end
      end
      S_EV_DRAIN: begin
        if (!status.ev_busy) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rteht_dp.sv =====
// datapath of the ring tap event hit test unit: config, event memory, sweeps
`default_nettype none

module rteht_dp #(
  parameter int MAX_EVENTS = rteht_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rteht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rteht_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [rteht_pkg::MIN_W-1:0]       in_start_minute,
  input  wire logic [rteht_pkg::MIN_W-1:0]       in_end_minute,
  input  wire logic [rteht_pkg::PIX_W-1:0]       in_tap_x,
  input  wire logic [rteht_pkg::PIX_W-1:0]       in_tap_y,
  input  wire rteht_pkg::cmd_t                   cmd,
  output rteht_pkg::status_t                     status,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [rteht_pkg::IDX_OUT_W-1:0]        out_event_index,
  output logic                                   out_found,
  output logic [rteht_pkg::MIN_W-1:0]            out_minute_of_day
);

  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int ENT_W = 2 * rteht_pkg::MIN_W;

  function automatic logic [10:0] circ_dist(input logic [10:0] a, input logic [10:0] b);
    logic [10:0] d;
    logic [10:0] o;
    d = (a > b) ? (a - b) : (b - a);
    o = rteht_pkg::DAY_MINUTES - d;
    return (o < d) ? o : d;
  endfunction

  // configuration
  logic [7:0] lx_r, ly_r, lw_r, lh_r;
  logic [5:0] th_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r <= rteht_pkg::LAYER_X_RST;
      ly_r <= rteht_pkg::LAYER_Y_RST;
      lw_r <= rteht_pkg::LAYER_W_RST;
      lh_r <= rteht_pkg::LAYER_H_RST;
      th_r <= rteht_pkg::RING_THK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rteht_pkg::CFG_LAYER_X:  lx_r <= cfg_wdata;
        rteht_pkg::CFG_LAYER_Y:  ly_r <= cfg_wdata;
        rteht_pkg::CFG_LAYER_W:  lw_r <= cfg_wdata;
        rteht_pkg::CFG_LAYER_H:  lh_r <= cfg_wdata;
        rteht_pkg::CFG_RING_THK: th_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // event table
  logic [ENT_W-1:0] ev_mem [MAX_EVENTS];
  logic [CNT_W-1:0] count_r;
  logic [10:0]      s_red, e_red;
  logic             not_full;

  assign s_red = (in_start_minute >= rteht_pkg::DAY_MINUTES) ?
                 (in_start_minute - rteht_pkg::DAY_MINUTES) : in_start_minute;
  assign e_red = (in_end_minute >= rteht_pkg::DAY_MINUTES) ?
                 (in_end_minute - rteht_pkg::DAY_MINUTES) : in_end_minute;
  assign not_full = count_r < CNT_W'(MAX_EVENTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && not_full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && not_full) begin
      ev_mem[count_r[IDX_W-1:0]] <= {s_red, e_red};
    end
  end

  // query geometry
  logic [7:0] tx_r, ty_r;
  logic [8:0] x0_r, y0_r;
  logic [7:0] w_r, h_r;
  logic [3:0] aw_r, ah_r;
  logic [4:0] bw_r, bh_r;
  logic [7:0] t2;
  logic [14:0] prod_w, prod_h;
  logic [3:0] aw, ah;

  assign t2     = {1'b0, th_r, 1'b0};
  assign prod_w = 15'(w_r[7:3]) * rteht_pkg::RECIP3;
  assign prod_h = 15'(h_r[7:3]) * rteht_pkg::RECIP3;
  assign aw     = prod_w[14:11];
  assign ah     = prod_h[14:11];

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      tx_r <= in_tap_x;
      ty_r <= in_tap_y;
    end
    if (cmd.geom) begin
      x0_r <= 9'(lx_r) + 9'(th_r);
      y0_r <= 9'(ly_r) + 9'(th_r);
      w_r  <= (lw_r > t2) ? (lw_r - t2) : 8'd0;
      h_r  <= (lh_r > t2) ? (lh_r - t2) : 8'd0;
    end
    if (cmd.divs) begin
      aw_r <= aw;
      ah_r <= ah;
      bw_r <= 5'(w_r - 8'(aw) * 8'(rteht_pkg::SIDE_POINTS));
      bh_r <= 5'(h_r - 8'(ah) * 8'(rteht_pkg::SIDE_POINTS));
    end
  end

  // ring point sweep: offsets floor(j*size/24) kept as quotient and remainder
  logic [1:0] side_r;
  logic [4:0] j_r, rw_r, rh_r;
  logic [6:0] pt_r;
  logic [7:0] qw_r, qh_r;
  logic [5:0] rw_sum, rh_sum;
  logic [9:0] px, py, x0e, y0e, we, he, txe, tye;

  assign rw_sum = 6'(rw_r) + 6'(bw_r);
  assign rh_sum = 6'(rh_r) + 6'(bh_r);
  assign x0e = 10'(x0_r);
  assign y0e = 10'(y0_r);
  assign we  = 10'(w_r);
  assign he  = 10'(h_r);
  assign txe = 10'(tx_r);
  assign tye = 10'(ty_r);

  always_comb begin
    case (side_r)
      2'd0: begin
        px = x0e + 10'(qw_r);
        py = y0e;
      end
      2'd1: begin
        px = x0e + we;
        py = y0e + 10'(qh_r);
      end
      2'd2: begin
        px = x0e + we - 10'(qw_r);
        py = y0e + he;
      end
      default: begin
        px = x0e;
        py = y0e + he - 10'(qh_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.geom) begin
      side_r <= 2'd0;
      j_r    <= 5'd0;
      pt_r   <= 7'd0;
      qw_r   <= 8'd0;
      qh_r   <= 8'd0;
      rw_r   <= 5'd0;
      rh_r   <= 5'd0;
    end else if (cmd.pt_step) begin
      pt_r <= pt_r + 7'd1;
      if (j_r == rteht_pkg::SIDE_LAST) begin
        side_r <= side_r + 2'd1;
        j_r    <= 5'd0;
        qw_r   <= 8'd0;
        qh_r   <= 8'd0;
        rw_r   <= 5'd0;
        rh_r   <= 5'd0;
      end else begin
        j_r <= j_r + 5'd1;
        if (rw_sum >= 6'(rteht_pkg::SIDE_POINTS)) begin
          rw_r <= 5'(rw_sum - 6'(rteht_pkg::SIDE_POINTS));
          qw_r <= qw_r + 8'(aw_r) + 8'd1;
        end else begin
          rw_r <= 5'(rw_sum);
          qw_r <= qw_r + 8'(aw_r);
        end
        if (rh_sum >= 6'(rteht_pkg::SIDE_POINTS)) begin
          rh_r <= 5'(rh_sum - 6'(rteht_pkg::SIDE_POINTS));
          qh_r <= qh_r + 8'(ah_r) + 8'd1;
        end else begin
          rh_r <= 5'(rh_sum);
          qh_r <= qh_r + 8'(ah_r);
        end
      end
    end
  end

  // distance stage then squared-distance compare stage
  logic       pa_vld_r;
  logic [6:0] pa_idx_r, best_pt_r;
  logic [9:0] dx_r, dy_r;
  logic [19:0] sqx, sqy;
  logic [20:0] sq, best_sq_r;

  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sq  = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
    end else begin
      pa_vld_r <= cmd.pt_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_step) begin
      pa_idx_r <= pt_r;
      dx_r     <= (px > txe) ? (px - txe) : (txe - px);
      dy_r     <= (py > tye) ? (py - tye) : (tye - py);
    end
    if (pa_vld_r && ((pa_idx_r == 7'd0) || (sq < best_sq_r))) begin
      best_sq_r <= sq;
      best_pt_r <= pa_idx_r;
    end
  end

  // minute of the nearest ring point
  logic [10:0] mraw, minute, minute_r;

  assign mraw   = 11'(best_pt_r) * rteht_pkg::MINUTES_PER_POINT
                  + rteht_pkg::RING_SHIFT_MINUTES;
  assign minute = (mraw >= rteht_pkg::DAY_MINUTES) ? (mraw - rteht_pkg::DAY_MINUTES) : mraw;

  always_ff @(posedge clk) begin
    if (cmd.minute) begin
      minute_r <= minute;
    end
  end

  // event sweep: memory read, distance, compare
  logic [CNT_W-1:0] ev_rd_r;
  logic             rd_vld_r, d_vld_r;
  logic [IDX_W-1:0] rd_idx_r, d_idx_r, best_ev_r;
  logic [ENT_W-1:0] rd_data_r;
  logic [10:0]      ev_s, ev_e, d_r, best_d_r, ev_d;
  logic             covers;

  assign ev_s = rd_data_r[ENT_W-1:rteht_pkg::MIN_W];
  assign ev_e = rd_data_r[rteht_pkg::MIN_W-1:0];

  always_comb begin
    if (ev_e < ev_s) begin
      covers = (minute_r >= ev_s) || (minute_r <= ev_e);
    end else begin
      covers = (minute_r >= ev_s) && (minute_r <= ev_e);
    end
    if (covers) begin
      ev_d = 11'd0;
    end else if (circ_dist(minute_r, ev_e) < circ_dist(minute_r, ev_s)) begin
      ev_d = circ_dist(minute_r, ev_e);
    end else begin
      ev_d = circ_dist(minute_r, ev_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      d_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.ev_step;
      d_vld_r  <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= ev_mem[ev_rd_r[IDX_W-1:0]];
    if (cmd.minute) begin
      ev_rd_r <= '0;
    end else if (cmd.ev_step) begin
      ev_rd_r <= ev_rd_r + CNT_W'(1);
    end
    rd_idx_r <= ev_rd_r[IDX_W-1:0];
    if (rd_vld_r) begin
      d_r     <= ev_d;
      d_idx_r <= rd_idx_r;
    end
    if (cmd.geom) begin
      best_ev_r <= '0;
    end else if (d_vld_r && ((d_idx_r == '0) || (d_r < best_d_r))) begin
      best_d_r  <= d_r;
      best_ev_r <= d_idx_r;
    end
  end

  // result register
  logic                              out_valid_r;
  logic [rteht_pkg::IDX_OUT_W-1:0]   out_idx_r;
  logic                              out_found_r;
  logic [rteht_pkg::MIN_W-1:0]       out_minute_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_idx_r    <= rteht_pkg::IDX_OUT_W'(best_ev_r);
      out_found_r  <= (count_r != '0);
      out_minute_r <= minute_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_index   = out_idx_r;
  assign out_found         = out_found_r;
  assign out_minute_of_day = out_minute_r;

  assign status.pt_last  = (side_r == 2'd3) && (j_r == rteht_pkg::SIDE_LAST);
  assign status.ev_empty = (count_r == '0);
  assign status.ev_last  = (CNT_W'(ev_rd_r + CNT_W'(1)) == count_r);
  assign status.ev_busy  = rd_vld_r || d_vld_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/ring_tap_event_hit_test_unit.sv =====
// top level of the ring tap event hit test unit
//
// usage:
//   in_ch carries one word per valid/ready handshake: operation plus the
//   append minutes and the tap point. clear and append finish in the cycle
//   they are accepted and give no result word; operation 3 is dropped.
//   a query produces exactly one word on out_ch: nearest event index,
//   found flag and the minute of day of the nearest ring point.
//   a query runs geometry setup, the divisions, a sweep of the 96 ring
//   points on a shared distance/square unit, the minute of the nearest
//   point, a sweep of the stored events through the memory read port and
//   the result load.
//   in_ch is held off while a query runs, until it has loaded its result;
//   clear and append words are taken back to back. the result sits in an
//   output register, so the next word is taken while it still waits; a
//   further query holds its result until out_ch frees the register.
//   cfg_we/cfg_index/cfg_wdata hold the layer geometry; write them only
//   while the unit is idle.
//   reset (rst_n low, synchronous) empties the event table, restores the
//   geometry defaults and drops any pending result.
`default_nettype none

`include "ring_tap_event_hit_test_unit_assert.svh"

module ring_tap_event_hit_test_unit #(
  parameter int MAX_EVENTS = rteht_pkg::MAX_EVENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  rteht_in_if.sink                               in_ch,
  rteht_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [rteht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rteht_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // command and status between sequencer and datapath
  rteht_pkg::cmd_t    cmd;
  rteht_pkg::status_t status;
  logic               in_ready;
  logic               query_acc;

  rteht_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  rteht_dp #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_start_minute   (in_ch.start_minute),
    .in_end_minute     (in_ch.end_minute),
    .in_tap_x          (in_ch.tap_x),
    .in_tap_y          (in_ch.tap_y),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_event_index   (out_ch.event_index),
    .out_found         (out_ch.found),
    .out_minute_of_day (out_ch.minute_of_day)
  );

  // input word taken only when the sequencer is idle
  assign in_ch.ready = in_ready;

  // query word accepted this cycle
  assign query_acc = in_ch.valid && in_ch.ready && (in_ch.operation == rteht_pkg::OP_QUERY);

  // an accepted query word starts the geometry setup next cycle
  `RTEHT_ASSERT_NXT(a_query_starts, query_acc, cmd.geom)
  // no word is taken while a sweep is running
  `RTEHT_ASSERT_IMP(a_busy_blocks_input, cmd.pt_step || cmd.ev_step, !in_ch.ready)
  // a loaded result shows up on out_ch in the next cycle
  `RTEHT_ASSERT_NXT(a_load_shows_result, cmd.load_out, out_ch.valid)

endmodule

`default_nettype wire

// ===== tb/tb_ring_tap_event_hit_test_unit.sv =====
// testbench for the ring tap event hit test unit: directed and random words, local predictor
`timescale 1ns / 100ps

module tb_ring_tap_event_hit_test_unit;

  localparam int TABLE_DEPTH = rteht_pkg::MAX_EVENTS_DEF;
  localparam int SIDE_PTS = int'(rteht_pkg::SIDE_POINTS);
  localparam int DAY_MIN = int'(rteht_pkg::DAY_MINUTES);
  localparam int RING_POINTS = 4 * SIDE_PTS;
  // long enough for one query in flight to finish
  localparam int SETTLE_CYCLES = 200;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_WORDS = 300;

  // one expected result word of a query
  typedef struct {
    logic [rteht_pkg::IDX_OUT_W-1:0] event_index;
    logic                            found;
    logic [rteht_pkg::MIN_W-1:0]     minute_of_day;
  } hit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rteht_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rteht_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rteht_in_if in_ch ();
  rteht_out_if out_ch ();

  ring_tap_event_hit_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the geometry registers
  int lay_x = rteht_pkg::LAYER_X_RST;
  int lay_y = rteht_pkg::LAYER_Y_RST;
  int lay_w = rteht_pkg::LAYER_W_RST;
  int lay_h = rteht_pkg::LAYER_H_RST;
  int ring_thk = rteht_pkg::RING_THK_RST;

  // shadow of the event table
  int ev_start [TABLE_DEPTH];
  int ev_end [TABLE_DEPTH];
  int ev_count = 0;

  // query results still owed by the unit, oldest first
  hit_t owed_hits [$];

  int error_count = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int sink_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hang never reaches the normal end
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("[%0t] %s: got %0d want %0d", $time, what, got, want);
  endtask

  // shortest way round the day clock between two minutes
  function automatic int clock_gap(int a, int b);
    int d;
    int o;
    d = (a > b) ? a - b : b - a;
    o = DAY_MIN - d;
    return (o < d) ? o : d;
  endfunction

  // minute of day of the ring point nearest the tap
  function automatic int ring_minute(int tx, int ty);
    int t2, x0, y0, w, h;
    int side, j, ow, oh, px, py, dx, dy, sq;
    int best_sq, best_pt;
    t2 = 2 * ring_thk;
    x0 = lay_x + ring_thk;
    y0 = lay_y + ring_thk;
    w = (lay_w > t2) ? lay_w - t2 : 0;
    h = (lay_h > t2) ? lay_h - t2 : 0;
    best_sq = 0;
    best_pt = 0;
    for (int p = 0; p < RING_POINTS; p++) begin
      side = p / SIDE_PTS;
      j = p % SIDE_PTS;
      ow = (j * w) / SIDE_PTS;
      oh = (j * h) / SIDE_PTS;
      // clockwise from the top-left corner
      case (side)
        0: begin
          px = x0 + ow;
          py = y0;
        end
        1: begin
          px = x0 + w;
          py = y0 + oh;
        end
        2: begin
          px = x0 + w - ow;
          py = y0 + h;
        end
        default: begin
          px = x0;
          py = y0 + h - oh;
        end
      endcase
      dx = (px > tx) ? px - tx : tx - px;
      dy = (py > ty) ? py - ty : ty - py;
      sq = dx * dx + dy * dy;
      // strict compare keeps the lowest point on a tie
      if (p == 0 || sq < best_sq) begin
        best_sq = sq;
        best_pt = p;
      end
    end
    return (best_pt * int'(rteht_pkg::MINUTES_PER_POINT)
            + int'(rteht_pkg::RING_SHIFT_MINUTES)) % DAY_MIN;
  endfunction

  function automatic hit_t nearest_event(int tx, int ty);
    hit_t r;
    int minute, best_ev, best_d, d, s, e;
    bit covered;
    minute = ring_minute(tx, ty);
    best_ev = 0;
    best_d = 0;
    for (int i = 0; i < ev_count; i++) begin
      s = ev_start[i];
      e = ev_end[i];
      // an end before the start wraps through midnight
      if (e < s)
        covered = (minute >= s) || (minute <= e);
      else
        covered = (minute >= s) && (minute <= e);
      if (covered) begin
        d = 0;
      end else begin
        d = clock_gap(minute, s);
        if (clock_gap(minute, e) < d)
          d = clock_gap(minute, e);
      end
      if (i == 0 || d < best_d) begin
        best_d = d;
        best_ev = i;
      end
    end
    r.event_index = best_ev[rteht_pkg::IDX_OUT_W-1:0];
    r.found = (ev_count != 0);
    r.minute_of_day = minute[rteht_pkg::MIN_W-1:0];
    return r;
  endfunction

  // update the table shadow for an accepted word and queue any result
  function automatic void absorb_word(rteht_pkg::op_t op, int smin, int emin, int tx, int ty);
    case (op)
      rteht_pkg::OP_CLEAR: ev_count = 0;
      rteht_pkg::OP_APPEND: begin
        if (smin >= DAY_MIN)
          smin -= DAY_MIN;
        if (emin >= DAY_MIN)
          emin -= DAY_MIN;
        // a full table drops the append
        if (ev_count < TABLE_DEPTH) begin
          ev_start[ev_count] = smin;
          ev_end[ev_count] = emin;
          ev_count++;
        end
      end
      rteht_pkg::OP_QUERY: owed_hits.push_back(nearest_event(tx, ty));
      default: ;
    endcase
  endfunction

  // present one word, hold it until the handshake, returns at a falling edge
  task automatic send_word(rteht_pkg::op_t op, int smin, int emin, int tx, int ty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.start_minute = smin[rteht_pkg::MIN_W-1:0];
    in_ch.end_minute = emin[rteht_pkg::MIN_W-1:0];
    in_ch.tap_x = tx[rteht_pkg::PIX_W-1:0];
    in_ch.tap_y = ty[rteht_pkg::PIX_W-1:0];
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    absorb_word(op, smin, emin, tx, ty);
    if (op != rteht_pkg::OP_NOP)
      words_sent++;
    @(negedge clk);
  endtask

  task automatic send_query(int tx, int ty);
    send_word(rteht_pkg::OP_QUERY, $urandom_range(2047), $urandom_range(2047), tx, ty);
  endtask

  task automatic send_append(int smin, int emin);
    send_word(rteht_pkg::OP_APPEND, smin, emin, $urandom_range(255), $urandom_range(255));
  endtask

  task automatic send_clear();
    send_word(rteht_pkg::OP_CLEAR, $urandom_range(2047), $urandom_range(2047),
              $urandom_range(255), $urandom_range(255));
  endtask

  // hold the input low until every owed result has come back
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (owed_hits.size() != 0)
      @(negedge clk);
  endtask

  // geometry changes only on an idle unit
  task automatic set_layer(int x, int y, int w, int h, int thk);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = rteht_pkg::CFG_LAYER_X;
    cfg_wdata = x[rteht_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = rteht_pkg::CFG_LAYER_Y;
    cfg_wdata = y[rteht_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = rteht_pkg::CFG_LAYER_W;
    cfg_wdata = w[rteht_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = rteht_pkg::CFG_LAYER_H;
    cfg_wdata = h[rteht_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index = rteht_pkg::CFG_RING_THK;
    cfg_wdata = thk[rteht_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    lay_x = x;
    lay_y = y;
    lay_w = w;
    lay_h = h;
    ring_thk = thk;
  endtask

  // mostly land near the layer rectangle so every side of the ring gets hit
  function automatic int pick_coord(int base, int span);
    int v;
    if ($urandom_range(9) < 7)
      v = base + $urandom_range(span + 4) - 2;
    else
      v = $urandom_range(255);
    if (v < 0)
      v = 0;
    if (v > 255)
      v = 255;
    return v;
  endfunction

  // in-range minutes mostly, now and then the full 11-bit field
  function automatic int pick_minute();
    if ($urandom_range(7) == 0)
      return $urandom_range(2047);
    return $urandom_range(DAY_MIN - 1);
  endfunction

  // query on an empty table, at reset geometry, plus an unknown operation
  task automatic test_empty_table();
    send_word(rteht_pkg::OP_NOP, 2047, 2047, 255, 255);
    send_query(0, 0);
    send_query(255, 255);
  endtask

  // minute wrap, out-of-range minutes, containment and ties between events
  task automatic test_event_edges();
    send_clear();
    send_append(1440, 1445);
    send_append(2047, 2047);
    send_append(1439, 30);
    send_append(900, 900);
    send_append(900, 900);
    send_query(134, 10);
    send_query(72, 158);
    send_query(10, 90);
    send_append(0, 1439);
    send_query(200, 40);
    send_clear();
    send_query(70, 70);
    send_append(200, 100);
    send_query(134, 158);
  endtask

  // ring thicker than the layer, far corners, tiniest layer
  task automatic test_geometry_extremes();
    set_layer(0, 0, 100, 100, 63);
    send_query(255, 255);
    set_layer(255, 255, 255, 255, 63);
    send_query(0, 0);
    send_query(255, 255);
    set_layer(0, 0, 1, 1, 0);
    send_query(128, 128);
  endtask

  // well-formed table fills with random content, with noise between
  task automatic run_random_words(int n_words);
    int first;
    int pick;
    int n_app;
    first = words_sent;
    while (words_sent - first < n_words) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        if ($urandom_range(3) != 0)
          send_clear();
        // now and then overfill the table
        n_app = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(10);
        repeat (n_app) send_append(pick_minute(), pick_minute());
        repeat ($urandom_range(4, 1))
          send_query(pick_coord(lay_x, lay_w), pick_coord(lay_y, lay_h));
      end else if (pick < 77) begin
        drain_results();
      end else begin
        send_word(rteht_pkg::op_t'($urandom_range(3)), $urandom_range(2047),
                  $urandom_range(2047), $urandom_range(255), $urandom_range(255));
      end
    end
  endtask

  task automatic random_layer();
    set_layer($urandom_range(255), $urandom_range(255), $urandom_range(255, 1),
              $urandom_range(255, 1), $urandom_range(63));
  endtask

  // result side: random backpressure and the per-field compare
  initial begin : result_check
    hit_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (owed_hits.size() == 0) begin
          report_mismatch("unexpected result word, minute", out_ch.minute_of_day, -1);
        end else begin
          want = owed_hits.pop_front();
          if (out_ch.event_index !== want.event_index)
            report_mismatch("event_index", out_ch.event_index, want.event_index);
          if (out_ch.found !== want.found)
            report_mismatch("found", out_ch.found, want.found);
          if (out_ch.minute_of_day !== want.minute_of_day)
            report_mismatch("minute_of_day", out_ch.minute_of_day, want.minute_of_day);
        end
      end
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rteht_pkg::CFG_LAYER_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = rteht_pkg::OP_CLEAR;
    in_ch.start_minute = '0;
    in_ch.end_minute = '0;
    in_ch.tap_x = '0;
    in_ch.tap_y = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 26;
    sink_idle_pct = 57;
    test_empty_table();
    test_event_edges();
    test_geometry_extremes();
    set_layer(rteht_pkg::LAYER_X_RST, rteht_pkg::LAYER_Y_RST, rteht_pkg::LAYER_W_RST,
              rteht_pkg::LAYER_H_RST, rteht_pkg::RING_THK_RST);
    run_random_words(RANDOM_WORDS / 2);
    random_layer();
    run_random_words(RANDOM_WORDS / 2);

    // swap the idling sides
    send_idle_pct = 57;
    sink_idle_pct = 26;
    set_layer(0, 0, 1, 1, 0);
    run_random_words(RANDOM_WORDS / 2);
    random_layer();
    run_random_words(RANDOM_WORDS / 2);

    // full rate both ways
    send_idle_pct = 0;
    sink_idle_pct = 0;
    set_layer(255, 255, 255, 255, 63);
    run_random_words(RANDOM_WORDS / 2);
    random_layer();
    run_random_words(RANDOM_WORDS / 2);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
